### src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the sequencer state type, the control and status structs passed
// between the sequencer and the datapath, and the fixed digit constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2da_pkg;

  // Width of one packed BCD digit.
  localparam int unsigned DigitW = 4;

  // Upper two bits of an ASCII digit ('0' is 6'b11_0000 in six bits).
  localparam logic [1:0] AsciiDigitHi = 2'b11;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StConvert,
    StSkip,
    StEmit
  } state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;         // capture a new value and clear the digit register
    logic dabble;       // one shift-and-correct conversion step
    logic digit_shift;  // move the digit register up by one digit
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic top_zero;     // the leading digit of the digit register is zero
    logic ovf;          // digits were lost off the top of the digit register
  } stat_t;

endpackage

### src/b2da_step.sv
// ----------------------------------------------------------------------------
// b2da_step: one shift-and-add-3 conversion step
// Corrects every BCD digit that is five or more by adding three, then shifts
// the digit string left by one bit, taking in the next binary bit. The bit
// pushed off the top digit is reported as a carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_step #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic [MAX_DIGITS*b2da_pkg::DigitW-1:0] bcd_i,
  input  logic                                   bit_i,
  output logic [MAX_DIGITS*b2da_pkg::DigitW-1:0] bcd_o,
  output logic                                   carry_o
);
  import b2da_pkg::*;

  localparam int unsigned BcdW = MAX_DIGITS * DigitW;

  logic [BcdW-1:0] adj;

  // Add three to each digit that would overflow past nine when doubled.
  always_comb begin
    adj = bcd_i;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_i[i*DigitW +: DigitW] >= DigitW'(5)) begin
        adj[i*DigitW +: DigitW] = bcd_i[i*DigitW +: DigitW] + DigitW'(3);
      end
    end
  end

  // Double the corrected digits and bring in the next binary bit.
  assign {carry_o, bcd_o} = {adj, bit_i};

endmodule

### src/b2da_fsm.sv
// ----------------------------------------------------------------------------
// b2da_fsm: conversion sequencer
// Runs one conversion step per input bit, skips the leading zero digits and
// then hands out the remaining digits one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_fsm #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  b2da_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic            out_last_o,
  output b2da_pkg::ctrl_t ctrl_o
);
  import b2da_pkg::*;

  localparam int unsigned BitCntW = $clog2(VALUE_BITS + 1);
  localparam int unsigned DigCntW = $clog2(MAX_DIGITS + 1);

  state_e               state_q, state_d;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]   dig_cnt_q, dig_cnt_d;
  logic                 last_step;
  logic                 skip_more;
  logic                 last_dig;

  assign last_step = (bit_cnt_q == BitCntW'(1));
  assign last_dig  = (dig_cnt_q == DigCntW'(1));
  // A leading zero is dropped unless it is the only digit left or digits
  // were already lost off the top.
  assign skip_more = stat_i.top_zero && !stat_i.ovf && !last_dig;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StConvert;
      end
      StConvert: begin
        if (last_step) state_d = StSkip;
      end
      StSkip: begin
        if (!skip_more) state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i && last_dig) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    out_last_o         = 1'b0;
    ctrl_o             = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      StConvert: begin
        ctrl_o.dabble = 1'b1;
      end
      StSkip: begin
        ctrl_o.digit_shift = skip_more;
      end
      StEmit: begin
        out_valid_o        = 1'b1;
        out_last_o         = last_dig;
        ctrl_o.digit_shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Bit and digit counters.
  always_comb begin
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    if (ctrl_o.load) begin
      bit_cnt_d = BitCntW'(VALUE_BITS);
      dig_cnt_d = DigCntW'(MAX_DIGITS);
    end else begin
      if (ctrl_o.dabble) bit_cnt_d = bit_cnt_q - BitCntW'(1);
      if (ctrl_o.digit_shift) dig_cnt_d = dig_cnt_q - DigCntW'(1);
    end
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

endmodule

### src/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII digit stream
// Converts one unsigned value to its decimal text, most significant digit
// first, no leading zeros, with the final digit flagged.
//
//   channel  | signals                         | beat
//   ---------+---------------------------------+-----------------------------
//   in       | in_valid_i, in_ready_o, value_i | one number
//   out      | out_valid_o, out_ready_i,       | one ASCII digit, last flag
//            | digit_char_o, last_digit_o      | on the final digit
//
// A new number is accepted only after the final digit of the previous one
// has been taken. The shared shift-and-add-3 unit runs once per input bit;
// leading zero digits are then dropped one per cycle, and each digit is one
// beat. A stalled output beat holds its digit until taken. in_ready_o is
// high only while idle.
// Reset returns the sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  digit_char_o,
  output logic        last_digit_o
);
  import b2da_pkg::*;

  localparam int unsigned BcdW = MAX_DIGITS * DigitW;

  ctrl_t                 ctrl;
  stat_t                 stat;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic                  ovf_q, ovf_d;
  logic [BcdW-1:0]       step_bcd;
  logic                  step_carry;

  // Sequencer.
  b2da_fsm #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (last_digit_o),
    .ctrl_o      (ctrl)
  );

  // Shared conversion unit.
  b2da_step #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_step (
    .bcd_i   (bcd_q),
    .bit_i   (bin_q[VALUE_BITS-1]),
    .bcd_o   (step_bcd),
    .carry_o (step_carry)
  );

  // Datapath next values.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    ovf_d = ovf_q;
    if (ctrl.load) begin
      bin_d = VALUE_BITS'(value_i);
      bcd_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl.dabble) begin
      bin_d = bin_q << 1;
      bcd_d = step_bcd;
      ovf_d = ovf_q | step_carry;
    end else if (ctrl.digit_shift) begin
      bcd_d = bcd_q << DigitW;
    end
  end

  // Datapath registers carry payload only.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    ovf_q <= ovf_d;
  end

  // Status back to the sequencer.
  assign stat.top_zero = (bcd_q[BcdW-1 -: DigitW] == '0);
  assign stat.ovf      = ovf_q;

  // The leading digit of the digit register is the current output beat.
  assign digit_char_o = {AsciiDigitHi, bcd_q[BcdW-1 -: DigitW]};

endmodule

### src/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for the binary to decimal ASCII block
// Watches the handshake ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  digit_char_o,
  input logic        last_digit_o
);

  // The block never takes a number while digits are still going out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output valid");

  // A stalled output beat holds its digit and flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(digit_char_o) && $stable(last_digit_o)))
    else $error("stalled output beat changed");

  // Every output beat is an ASCII decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o[5:4] == 2'b11 && digit_char_o[3:0] <= 4'd9))
    else $error("output beat is not a decimal digit");

  // Once the final digit is taken, no further beat follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_digit_o) |=> !out_valid_o)
    else $error("beat after the final digit");

  // An accepted number closes the input until its digits are out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a number was taken");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
